FILE: design/one_wire_bus_master_macros.svh
// Assertion macros used by the bus master top file.
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define OWB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("one_wire_bus_master: same-cycle check failed");

// Implication with the consequent checked in the following cycle.
`define OWB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("one_wire_bus_master: next-cycle check failed");

`endif

FILE: design/owb_pkg.sv
package owb_pkg;

  localparam int CNT_W = 16;

  // Item kinds as they arrive on the command channel.
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_RESET = 3'd1;
  localparam logic [2:0] KIND_WBYTE = 3'd2;
  localparam logic [2:0] KIND_RBYTE = 3'd3;
  localparam logic [2:0] KIND_WBIT  = 3'd4;
  localparam logic [2:0] KIND_RBIT  = 3'd5;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [2:0] {
    CFG_RESET_PULSE_LEN      = 3'd0,
    CFG_SLOT_LEN             = 3'd1,
    CFG_WRITE_ONE_PULSE_LEN  = 3'd2,
    CFG_WRITE_ZERO_PULSE_LEN = 3'd3,
    CFG_READ_PULSE_LEN       = 3'd4,
    CFG_PRESENCE_THRESHOLD   = 3'd5,
    CFG_READ_THRESHOLD       = 3'd6
  } cfg_idx_t;

  // Operating mode; the codes follow the item kinds.
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_RESET = 3'd1,
    MODE_WBYTE = 3'd2,
    MODE_RBYTE = 3'd3,
    MODE_WBIT  = 3'd4,
    MODE_RBIT  = 3'd5
  } mode_t;

  typedef struct packed {
    logic [14:0] reset_pulse_len;
    logic [15:0] slot_len;
    logic [15:0] write_one_pulse_len;
    logic [15:0] write_zero_pulse_len;
    logic [15:0] read_pulse_len;
    logic [15:0] presence_threshold;
    logic [15:0] read_threshold;
  } cfg_t;

  typedef struct packed {
    logic       line_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] pulse_end;
    logic [CNT_W-1:0] slot_end;
  } slot_t;

  // Pulse and slot limits for the slot that opens now.
  function automatic slot_t slot_bounds(input mode_t m, input logic lsb, input cfg_t c);
    slot_t       s;
    logic [31:0] p;
    logic [31:0] e;
    if (m == MODE_RESET) begin
      p = 32'(c.reset_pulse_len);
      e = 32'({c.reset_pulse_len, 1'b0});
    end else begin
      e = 32'(c.slot_len);
      if (m == MODE_RBYTE || m == MODE_RBIT) begin
        p = 32'(c.read_pulse_len);
      end else if (lsb) begin
        p = 32'(c.write_one_pulse_len);
      end else begin
        p = 32'(c.write_zero_pulse_len);
      end
    end
    s.pulse_end = p[CNT_W-1:0];
    s.slot_end  = e[CNT_W-1:0];
    return s;
  endfunction

endpackage

FILE: design/owb_item_if.sv
interface owb_item_if;
  import owb_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data;
  logic       line_level;

  modport source (output valid, kind, data, line_level, input ready);
  modport sink (input valid, kind, data, line_level, output ready);
endinterface

FILE: design/owb_res_if.sv
interface owb_res_if;
  import owb_pkg::*;
  logic       valid;
  logic       ready;
  logic       line_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;

  modport source (output valid, line_low, busy_res, done_res, presence, read_data,
                  input ready);
  modport sink (input valid, line_low, busy_res, done_res, presence, read_data,
                output ready);
endinterface

FILE: design/owb_cfg_if.sv
interface owb_cfg_if;
  import owb_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

FILE: design/owb_cfg_regs.sv
module owb_cfg_regs
  import owb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_pulse_len      <= 15'd480;
      cfg.slot_len             <= 16'd70;
      cfg.write_one_pulse_len  <= 16'd6;
      cfg.write_zero_pulse_len <= 16'd60;
      cfg.read_pulse_len       <= 16'd6;
      cfg.presence_threshold   <= 16'd540;
      cfg.read_threshold       <= 16'd15;
    end else if (wr_en) begin
      case (wr_index)
        CFG_RESET_PULSE_LEN:      cfg.reset_pulse_len      <= wr_data[14:0];
        CFG_SLOT_LEN:             cfg.slot_len             <= wr_data;
        CFG_WRITE_ONE_PULSE_LEN:  cfg.write_one_pulse_len  <= wr_data;
        CFG_WRITE_ZERO_PULSE_LEN: cfg.write_zero_pulse_len <= wr_data;
        CFG_READ_PULSE_LEN:       cfg.read_pulse_len       <= wr_data;
        CFG_PRESENCE_THRESHOLD:   cfg.presence_threshold   <= wr_data;
        CFG_READ_THRESHOLD:       cfg.read_threshold       <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/owb_slot_engine.sv
module owb_slot_engine
  import owb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [2:0] kind,
  input  logic [7:0] data,
  input  logic       line_level,
  input  cfg_t       cfg,
  output res_t       res_next
);

  mode_t            mode, mode_next;
  logic [CNT_W-1:0] tick_count, tick_count_next;
  logic [CNT_W-1:0] pulse_end, pulse_end_next;
  logic [CNT_W-1:0] slot_end, slot_end_next;
  logic [CNT_W-1:0] capture_time, capture_time_next;
  logic [2:0]       bit_index, bit_index_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic             previous_level, previous_level_next;
  logic             presence_flag, presence_flag_next;
  logic             done;
  logic             read_bit;
  logic             open_slot;
  slot_t            bounds;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else if (step) begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      pulse_end      <= '0;
      slot_end       <= '0;
      capture_time   <= '0;
      bit_index      <= '0;
      shift_byte     <= '0;
      previous_level <= 1'b1;
      presence_flag  <= 1'b0;
    end else if (step) begin
      tick_count     <= tick_count_next;
      pulse_end      <= pulse_end_next;
      slot_end       <= slot_end_next;
      capture_time   <= capture_time_next;
      bit_index      <= bit_index_next;
      shift_byte     <= shift_byte_next;
      previous_level <= previous_level_next;
      presence_flag  <= presence_flag_next;
    end
  end

  always_comb begin
    mode_next           = mode;
    tick_count_next     = tick_count;
    capture_time_next   = capture_time;
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    previous_level_next = previous_level;
    presence_flag_next  = presence_flag;
    done                = 1'b0;
    open_slot           = 1'b0;
    read_bit            = 1'b0;

    if (kind == KIND_TICK) begin
      if (mode != MODE_IDLE) begin
        if (!previous_level && line_level) begin
          capture_time_next = tick_count;
        end
        if (tick_count >= slot_end) begin
          // The decision uses this tick's capture if the line rose on it.
          read_bit = (32'(capture_time_next) <= 32'(cfg.read_threshold));
          case (mode)
            MODE_RESET: begin
              presence_flag_next = (32'(capture_time_next) > 32'(cfg.presence_threshold));
              done = 1'b1;
            end
            MODE_WBIT: begin
              shift_byte_next = {1'b0, shift_byte[7:1]};
              done = 1'b1;
            end
            MODE_RBIT: begin
              shift_byte_next = {7'b0, read_bit};
              done = 1'b1;
            end
            MODE_WBYTE: shift_byte_next = {1'b0, shift_byte[7:1]};
            default:    shift_byte_next = {read_bit, shift_byte[7:1]};
          endcase
          if (!done) begin
            if (bit_index == LAST_BIT) begin
              done = 1'b1;
            end else begin
              bit_index_next = bit_index + 3'd1;
              open_slot = 1'b1;
            end
          end
          if (done) begin
            mode_next = MODE_IDLE;
          end
        end else begin
          tick_count_next = tick_count + CNT_W'(1);
        end
      end
      previous_level_next = line_level;
    end else if (kind inside {[KIND_RESET:KIND_RBIT]} && mode == MODE_IDLE) begin
      mode_next      = mode_t'(kind);
      bit_index_next = '0;
      open_slot      = 1'b1;
      case (kind)
        KIND_WBYTE: shift_byte_next = data;
        KIND_WBIT:  shift_byte_next = {7'b0, data[0]};
        KIND_RBYTE,
        KIND_RBIT:  shift_byte_next = '0;
        default:    ;
      endcase
    end

    bounds = slot_bounds(mode_next, shift_byte_next[0], cfg);
    if (open_slot) begin
      pulse_end_next  = bounds.pulse_end;
      slot_end_next   = bounds.slot_end;
      tick_count_next = '0;
    end else begin
      pulse_end_next = pulse_end;
      slot_end_next  = slot_end;
    end

    res_next.line_low  = (mode_next != MODE_IDLE) && (tick_count_next < pulse_end_next);
    res_next.busy_res  = (mode_next != MODE_IDLE);
    res_next.done_res  = done;
    res_next.presence  = presence_flag_next;
    res_next.read_data = shift_byte_next;
  end

endmodule

FILE: design/one_wire_bus_master.sv
// One-wire bus master, driven by a stream of items on the cmd channel.
// Each item is a command (reset, write byte, read byte, write bit, read
// bit) or a microsecond tick that carries the sampled bus level. Every
// accepted item yields exactly one transaction on the res channel with the
// line drive for the coming tick, busy, done, presence and read data.
// The cfg channel writes the seven timing registers; it is always ready and
// should only be used while the block is idle.
// An accepted item is held in the input register; when it steps, the slot
// engine result is loaded into the output register, which drives res.
// Throughput is one item per cycle while res is not stalled, set by the
// update of the slot engine state on each step.
// When res is stalled the output register holds its transaction and the
// input register holds one more item; cmd ready then drops until res moves.
// Synchronous reset empties both registers, loads the default timings and
// returns the engine to idle with the bus level taken as high.
module one_wire_bus_master
  import owb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  owb_item_if.sink   cmd,
  owb_res_if.source  res,
  owb_cfg_if.sink    cfg
);

`include "one_wire_bus_master_macros.svh"

  logic       in_valid;
  logic [2:0] in_kind;
  logic [7:0] in_data;
  logic       in_level;
  logic       res_valid;
  res_t       res_reg;
  res_t       res_next;
  cfg_t       cfg_regs;
  logic       step;

  assign step      = in_valid && (!res_valid || res.ready);
  assign cmd.ready = !in_valid || step;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_kind  <= cmd.kind;
      in_data  <= cmd.data;
      in_level <= cmd.line_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= res_next;
    end
  end

  owb_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.wdata),
    .cfg      (cfg_regs)
  );

  owb_slot_engine u_slot_engine (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .kind       (in_kind),
    .data       (in_data),
    .line_level (in_level),
    .cfg        (cfg_regs),
    .res_next   (res_next)
  );

  assign res.valid     = res_valid;
  assign res.line_low  = res_reg.line_low;
  assign res.busy_res  = res_reg.busy_res;
  assign res.done_res  = res_reg.done_res;
  assign res.presence  = res_reg.presence;
  assign res.read_data = res_reg.read_data;

  `OWB_ASSERT_NEXT(a_step_gives_result, step, res_valid)
  `OWB_ASSERT_NOW(a_full_stall_blocks_cmd, in_valid && res_valid && !res.ready, !cmd.ready)
  `OWB_ASSERT_NOW(a_drive_only_when_busy, res_valid && res_reg.line_low, res_reg.busy_res)
  `OWB_ASSERT_NOW(a_done_ends_busy, res_valid && res_reg.done_res, !res_reg.busy_res)

endmodule
